@@ rtl/core/drq_pkg.sv @@
// Shared constants and types for the directed reachability query block.
package drq_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VIDX_W       = 6;
	localparam int CNT_W        = 7;
	localparam int WEIGHT_W     = 8;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 8;

	typedef logic [MAX_VERTICES-1:0] row_t;
	typedef logic [VIDX_W-1:0]       vidx_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic {
		REQ_EDGE  = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

	typedef enum logic {
		STATUS_OK    = 1'b0,
		STATUS_RANGE = 1'b1
	} status_t;

endpackage

@@ rtl/core/drq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module drq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/directed_reachability_query.sv @@
// Directed reachability query: adjacency matrix in RAM with a row-by-row search.
// Usage:
//   Requests enter on s_axis_*: tuser is req_type, tdata holds node_a, node_b
//   and edge_weight. An edge request sets (weight nonzero) or clears (weight
//   zero) the bit node_a -> node_b in a 64 x 64 adjacency RAM. A query request
//   answers whether node_b is reachable from node_a or node_a from node_b.
//   Each request yields one result on m_axis_*: tdata[0] is path_found, tuser
//   is status (1 when a vertex is at or above vertex_count).
//   cfg_we/cfg_wdata write vertex_count; write it only while the block is idle.
// Sequencing:
//   One request at a time. An edge request reads the row, merges and writes it
//   back, then loads the result; an out-of-range request goes straight to the
//   result load. A query runs up to two searches; each expanded vertex takes
//   one adjacency row read, then a merge into the visited and frontier masks,
//   and each search ends on detecting an empty frontier.
// Reset: arst_n clears all row-valid flags so the matrix reads as empty; no
//   clearing pass is needed. vertex_count returns to 64.
// Stall: the result sits in an output register. A new request is taken while
//   it waits; a finished request holds in its final state until the slot frees.
module directed_reachability_query
	import drq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CNT_W-1:0]      cfg_wdata,     // vertex_count
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // node_a[5:0], node_b[11:6], edge_weight[19:12]
	input  logic                  s_axis_tuser,  // req_type
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // path_found[0]
	output logic                  m_axis_tuser   // status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_PICK,
		ST_EXPAND,
		ST_DONE
	} state_t;

	state_t    state_q;
	cnt_t      vcount_q;
	row_t      row_valid_q;
	row_t      visited_q;
	row_t      frontier_q;
	vidx_t     a_q;
	vidx_t     b_q;
	logic      set_q;
	logic      pass_q;
	logic      rd_vld_s1;
	logic      res_found_q;
	logic      res_status_q;
	logic      m_valid_q;
	logic      m_found_q;
	logic      m_status_q;

	vidx_t     in_a;
	vidx_t     in_b;
	logic [WEIGHT_W-1:0] in_w;
	cnt_t      eff_n;
	logic      in_err;
	row_t      vmask;
	vidx_t     cur;
	logic      out_free;
	logic      accept;

	logic      ram_we;
	vidx_t     ram_waddr;
	row_t      ram_wdata;
	vidx_t     ram_raddr;
	row_t      ram_rdata;
	row_t      row;
	row_t      new_bits;

	assign in_a = s_axis_tdata[VIDX_W-1:0];
	assign in_b = s_axis_tdata[2*VIDX_W-1:VIDX_W];
	assign in_w = s_axis_tdata[2*VIDX_W+WEIGHT_W-1:2*VIDX_W];

	assign eff_n  = (vcount_q > cnt_t'(MAX_VERTICES)) ? cnt_t'(MAX_VERTICES) : vcount_q;
	assign in_err = ({1'b0, in_a} >= eff_n) || ({1'b0, in_b} >= eff_n);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			vmask[i] = (cnt_t'(i) < eff_n);
		end
	end

	// lowest pending frontier vertex
	always_comb begin
		cur = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (frontier_q[i]) begin
				cur = vidx_t'(i);
			end
		end
	end

	// rows never written read as empty
	assign row      = rd_vld_s1 ? ram_rdata : '0;
	assign new_bits = row & vmask & ~visited_q;

	always_comb begin
		ram_raddr = (state_q == ST_IDLE) ? in_a : cur;
		ram_we    = (state_q == ST_EDGE);
		ram_waddr = a_q;
		ram_wdata = row;
		ram_wdata[b_q] = set_q;
	end

	drq_ram #(
		.WIDTH (MAX_VERTICES),
		.DEPTH (MAX_VERTICES)
	) u_adj_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vcount_q     <= cnt_t'(MAX_VERTICES);
			row_valid_q  <= '0;
			visited_q    <= '0;
			frontier_q   <= '0;
			a_q          <= '0;
			b_q          <= '0;
			set_q        <= 1'b0;
			pass_q       <= 1'b0;
			rd_vld_s1    <= 1'b0;
			res_found_q  <= 1'b0;
			res_status_q <= STATUS_OK;
			m_valid_q    <= 1'b0;
			m_found_q    <= 1'b0;
			m_status_q   <= STATUS_OK;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			rd_vld_s1 <= row_valid_q[ram_raddr];
			// load a finished result, or drop the one just taken
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						a_q   <= in_a;
						b_q   <= in_b;
						set_q <= (in_w != '0);
						if (in_err) begin
							res_found_q  <= 1'b0;
							res_status_q <= STATUS_RANGE;
							state_q      <= ST_DONE;
						end else if (req_type_t'(s_axis_tuser) == REQ_EDGE) begin
							state_q <= ST_EDGE;
						end else begin
							visited_q  <= row_t'(1) << in_a;
							frontier_q <= row_t'(1) << in_a;
							pass_q     <= 1'b0;
							state_q    <= ST_PICK;
						end
					end
				end
				ST_EDGE: begin
					row_valid_q[a_q] <= 1'b1;
					res_found_q      <= 1'b0;
					res_status_q     <= STATUS_OK;
					state_q          <= ST_DONE;
				end
				ST_PICK: begin
					if (frontier_q == '0) begin
						if (!pass_q && !visited_q[b_q]) begin
							// start the reverse search
							visited_q  <= row_t'(1) << b_q;
							frontier_q <= row_t'(1) << b_q;
							pass_q     <= 1'b1;
						end else begin
							res_found_q  <= pass_q ? visited_q[a_q] : 1'b1;
							res_status_q <= STATUS_OK;
							state_q      <= ST_DONE;
						end
					end else begin
						frontier_q[cur] <= 1'b0;
						state_q         <= ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					visited_q  <= visited_q | new_bits;
					frontier_q <= frontier_q | new_bits;
					state_q    <= ST_PICK;
				end
				ST_DONE: begin
					if (out_free) begin
						m_found_q  <= res_found_q;
						m_status_q <= res_status_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, m_found_q};
	assign m_axis_tuser  = m_status_q;

endmodule

@@ sim/directed_reachability_query_test.sv @@
// Stream testbench for directed_reachability_query against a bit-matrix predictor.
`timescale 1ns / 100ps

module directed_reachability_query_test;
	import drq_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_STALL     = 400;
	localparam int STALL_AFTER    = 200;
	localparam int PHASE_COUNTS [11] = '{8, 64, 16, 5, 127, 3, 0, 32, 2, 64, 12};
	localparam int PHASE_SIZES  [11] = '{60, 60, 60, 60, 55, 60, 15, 60, 50, 60, 60};

	typedef struct packed {
		req_type_t             kind;
		vidx_t                 node_a;
		vidx_t                 node_b;
		logic [WEIGHT_W-1:0]   weight;
	} request_t;

	typedef struct packed {
		logic    path_found;
		status_t status;
	} answer_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CNT_W-1:0]      cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tready = 1'b0;
	wire                   s_axis_tready;
	wire                   m_axis_tvalid;
	wire  [OUT_DATA_W-1:0] m_axis_tdata;
	wire                   m_axis_tuser;

	row_t     adjacency_model [MAX_VERTICES] = '{default: '0};
	cnt_t     vertex_limit = 7'd64;
	request_t request_queue[$];
	answer_t  expected_answers[$];
	request_t offered;
	int       issued = 0;
	int       answered = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       stall_left = 0;
	bit       in_taken = 1'b0;
	bit       idle_on = 1'b1;
	bit       long_stall_done = 1'b0;

	directed_reachability_query uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic row_t in_range_mask(int n);
		if (n >= MAX_VERTICES)
			return '1;
		return (row_t'(1) << n) - row_t'(1);
	endfunction

	// Expand the frontier until it empties; only vertices under the count are walked.
	function automatic bit reaches(int src, int dst, row_t valid);
		row_t seen;
		row_t front;
		row_t fresh;
		seen = '0;
		seen[src] = 1'b1;
		front = seen;
		while (front != '0) begin
			for (int v = 0; v < MAX_VERTICES; v++) begin
				if (front[v]) begin
					front[v] = 1'b0;
					fresh = adjacency_model[v] & valid & ~seen;
					seen |= fresh;
					front |= fresh;
				end
			end
		end
		return seen[dst];
	endfunction

	function automatic answer_t predict_answer(request_t r);
		answer_t ans;
		int      n;
		row_t    valid;
		n = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_limit);
		valid = in_range_mask(n);
		ans.path_found = 1'b0;
		ans.status = STATUS_OK;
		if (int'(r.node_a) >= n || int'(r.node_b) >= n) begin
			ans.status = STATUS_RANGE;
			return ans;
		end
		if (r.kind == REQ_EDGE)
			adjacency_model[r.node_a][r.node_b] = (r.weight != '0);
		else
			ans.path_found = reaches(r.node_a, r.node_b, valid) ||
				reaches(r.node_b, r.node_a, valid);
		return ans;
	endfunction

	// Vertices often come from the first 12 so paths get long; a few span the full 64-vertex range.
	function automatic request_t make_request(int n);
		request_t r;
		int       span;
		span = (n > MAX_VERTICES) ? MAX_VERTICES : n;
		if (span > 12 && $urandom_range(1) == 1)
			span = 12;
		r.kind = ($urandom_range(99) < 40) ? REQ_QUERY : REQ_EDGE;
		if (span == 0 || $urandom_range(99) < 12) begin
			r.node_a = vidx_t'($urandom_range(MAX_VERTICES - 1));
			r.node_b = vidx_t'($urandom_range(MAX_VERTICES - 1));
		end else begin
			r.node_a = vidx_t'($urandom_range(span - 1));
			r.node_b = vidx_t'($urandom_range(span - 1));
		end
		if ($urandom_range(3) == 0)
			r.weight = '0;
		else
			r.weight = WEIGHT_W'($urandom_range(255));
		return r;
	endfunction

	task automatic add_request(req_type_t kind, int a, int b, int w);
		request_t r;
		r.kind = kind;
		r.node_a = vidx_t'(a);
		r.node_b = vidx_t'(b);
		r.weight = WEIGHT_W'(w);
		request_queue.push_back(r);
	endtask

	// Hold until every issued request has been answered.
	task automatic wait_drained();
		while (request_queue.size() != 0 || issued != answered)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_vertex_count(int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cnt_t'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		vertex_limit = cnt_t'(value);
	endtask

	task automatic run_random_phase(int count, int items);
		write_vertex_count(count);
		for (int i = 0; i < items; i++)
			request_queue.push_back(make_request(count));
		wait_drained();
	endtask

	// Request driver: present the next pending request once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			in_taken = 1'b0;
			if (request_queue.size() != 0 && !(idle_on && $urandom_range(99) < 9)) begin
				offered = request_queue.pop_front();
				issued++;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {{(IN_DATA_W - 20){1'b0}}, offered.weight,
					offered.node_b, offered.node_a};
				s_axis_tuser <= offered.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random back-pressure plus one long hold-off.
	always @(negedge clk) begin
		if (!long_stall_done && answered >= STALL_AFTER) begin
			long_stall_done = 1'b1;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(idle_on && $urandom_range(99) < 9);
		end
	end

	always @(posedge clk) begin
		answer_t want;
		bit      moved;
		moved = 1'b0;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_answers.push_back(predict_answer(offered));
			in_taken = 1'b1;
			moved = 1'b1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			answered++;
			moved = 1'b1;
			if (expected_answers.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got path %0b status %0b",
					$time, m_axis_tdata[0], m_axis_tuser);
			end else begin
				want = expected_answers.pop_front();
				if (m_axis_tdata !== {{(OUT_DATA_W - 1){1'b0}}, want.path_found}) begin
					mismatches++;
					$display("%0t: path_found mismatch, expected %0h, got %0h",
						$time, want.path_found, m_axis_tdata);
				end
				if (m_axis_tuser !== want.status) begin
					mismatches++;
					$display("%0t: status mismatch, expected %0b, got %0b",
						$time, want.status, m_axis_tuser);
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Full count: set, clear, chain through the top vertex, self loops.
		add_request(REQ_EDGE, 0, 63, 255);
		add_request(REQ_QUERY, 0, 63, 0);
		add_request(REQ_QUERY, 63, 0, 0);
		add_request(REQ_QUERY, 5, 5, 0);
		add_request(REQ_QUERY, 0, 1, 0);
		add_request(REQ_EDGE, 63, 1, 1);
		add_request(REQ_QUERY, 0, 1, 255);
		add_request(REQ_QUERY, 1, 0, 0);
		add_request(REQ_EDGE, 63, 63, 128);
		add_request(REQ_QUERY, 63, 63, 0);
		add_request(REQ_EDGE, 0, 63, 0);
		add_request(REQ_QUERY, 0, 1, 0);
		add_request(REQ_QUERY, 1, 63, 0);
		add_request(REQ_EDGE, 0, 63, 77);
		add_request(REQ_EDGE, 42, 21, 0);
		wait_drained();

		// Zero count rejects every index.
		write_vertex_count(0);
		add_request(REQ_EDGE, 0, 0, 1);
		add_request(REQ_QUERY, 0, 0, 0);
		wait_drained();

		write_vertex_count(1);
		add_request(REQ_QUERY, 0, 0, 0);
		add_request(REQ_QUERY, 0, 1, 0);
		add_request(REQ_EDGE, 1, 0, 5);
		add_request(REQ_EDGE, 0, 0, 3);
		wait_drained();

		// Shrunk count hides the path through vertex 63, but keeps the edges.
		write_vertex_count(2);
		add_request(REQ_QUERY, 0, 1, 0);
		add_request(REQ_QUERY, 1, 1, 0);
		wait_drained();

		write_vertex_count(127);
		add_request(REQ_QUERY, 0, 1, 0);
		add_request(REQ_EDGE, 0, 63, 0);
		wait_drained();

		for (int p = 0; p < 11; p++) begin
			idle_on = (p != 3);
			run_random_phase(PHASE_COUNTS[p], PHASE_SIZES[p]);
		end
		idle_on = 1'b1;

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
